/* rtl/psf_pkg.sv */
// Shared types, constants and helper functions of the prioritized steering force block.
// Depends on nothing; every other file of the block imports it.
package psf_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int PATH_DEPTH = 16;
   localparam int PTR_W      = $clog2(PATH_DEPTH);
   localparam int CNT_W      = $clog2(PATH_DEPTH + 1);

   // Accumulated force needs 35 signed bits; magnitudes need 33 unsigned bits.
   localparam int TOT_W  = 35;
   localparam int ROOT_W = 33;
   localparam int PROD_W = 64;
   localparam int RAD_W  = 66;
   localparam int REM_W  = 36;
   localparam int CFG_W  = 31;

   localparam int ARRIVE_EPS = (1 << FRAC_BITS) / 100000;
   localparam logic [CFG_W-1:0] FIX_ONE = CFG_W'(1 << FRAC_BITS);

   localparam int REQ_DW = 9 * 32;
   localparam int RSP_DW = ((3 * 32 + CNT_W + 7) / 8) * 8;
   localparam int ADDR_W = 5;

   localparam logic [1:0] KIND_STEP  = 2'd0;
   localparam logic [1:0] KIND_PUSH  = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   localparam logic [1:0] BEH_FLEE   = 2'd0;
   localparam logic [1:0] BEH_SEEK   = 2'd1;
   localparam logic [1:0] BEH_ARRIVE = 2'd2;
   localparam logic [1:0] BEH_PATH   = 2'd3;

   localparam logic [2:0] REG_ENABLE    = 3'd0;
   localparam logic [2:0] REG_MAX_FORCE = 3'd1;
   localparam logic [2:0] REG_MAX_SPEED = 3'd2;
   localparam logic [2:0] REG_DECEL     = 3'd3;
   localparam logic [2:0] REG_RADIUS    = 3'd4;

   typedef logic [2:0][TOT_W-1:0] vec_type;
   typedef logic [2:0][31:0]      word3_type;

   typedef enum logic {
      OP_MAG    = 1'b0,
      OP_MULDIV = 1'b1
   } arith_op_type;

   typedef struct packed {
      logic [3:0]       enable;
      logic [CFG_W-1:0] max_force;
      logic [CFG_W-1:0] max_speed;
      logic [CFG_W-1:0] decel;
      logic [CFG_W-1:0] radius;
   } cfg_type;

   typedef struct packed {
      logic [1:0] kind;
      word3_type  pos;
      word3_type  vel;
      word3_type  goal;
   } item_type;

   typedef struct packed {
      logic              start;
      arith_op_type      op;
      vec_type           vec;
      logic [ROOT_W-1:0] a;
      logic [CFG_W-1:0]  num;
      logic [ROOT_W-1:0] den;
   } arith_cmd_type;

   typedef struct packed {
      logic              done;
      logic [ROOT_W-1:0] root;
      logic [PROD_W-1:0] quot;
   } arith_rsp_type;

   typedef struct packed {
      logic [31:0]      force_x;
      logic [31:0]      force_y;
      logic [31:0]      force_z;
      logic             limit_reached;
      logic [CNT_W-1:0] waypoints_left;
      logic             push_dropped;
   } rsp_type;

   function automatic logic [31:0] clamp_abs(input logic [TOT_W-1:0] x);
      logic [TOT_W-1:0] mag;
      mag = x[TOT_W-1] ? (~x + 1'b1) : x;
      if (|mag[TOT_W-1:32]) begin
         return 32'hFFFF_FFFF;
      end
      return mag[31:0];
   endfunction

   function automatic logic [31:0] sat32(input logic [TOT_W-1:0] x);
      if (x[TOT_W-1:31] == '0 || x[TOT_W-1:31] == '1) begin
         return x[31:0];
      end else if (x[TOT_W-1]) begin
         return 32'h8000_0000;
      end
      return 32'h7FFF_FFFF;
   endfunction

   function automatic logic [TOT_W-1:0] sext32(input logic [31:0] v);
      return {{(TOT_W-32){v[31]}}, v};
   endfunction

   // Ring index: the sum is always below twice the depth.
   function automatic logic [PTR_W-1:0] wrap_ptr(input logic [PTR_W:0] s);
      logic [PTR_W:0] t;
      t = (s >= (PTR_W+1)'(PATH_DEPTH)) ? s - (PTR_W+1)'(PATH_DEPTH) : s;
      return t[PTR_W-1:0];
   endfunction

endpackage

/* rtl/psf_wp_mem.sv */
// Waypoint ring memory: one write port, one read port with registered read data.
// Depends on psf_pkg.
module psf_wp_mem (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [psf_pkg::PTR_W-1:0] wr_addr,
   input  psf_pkg::word3_type        wr_data,
   input  logic                      rd_en,
   input  logic [psf_pkg::PTR_W-1:0] rd_addr,
   output psf_pkg::word3_type        rd_data
);
   import psf_pkg::*;

   word3_type mem [PATH_DEPTH];
   word3_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/psf_arith.sv */
// Shared arithmetic unit: vector magnitude (squares, then a bit-serial square root)
// and multiply-then-divide (one multiply, then a bit-serial restoring divide). Uses psf_pkg.
module psf_arith (
   input  logic                   clock,
   input  logic                   reset,
   input  psf_pkg::arith_cmd_type cmd,
   output psf_pkg::arith_rsp_type rsp
);
   import psf_pkg::*;

   localparam int ITER_W = $clog2(PROD_W);

   typedef enum logic [6:0] {
      AR_IDLE = 7'b0000001,
      AR_SQ   = 7'b0000010,
      AR_ADD  = 7'b0000100,
      AR_SQRT = 7'b0001000,
      AR_MUL  = 7'b0010000,
      AR_DIV  = 7'b0100000,
      AR_DONE = 7'b1000000
   } ar_state_type;

   ar_state_type      state_ff, state_in;
   vec_type           vec_ff, vec_in;
   logic [ROOT_W-1:0] a_ff, a_in, den_ff, den_in;
   logic [CFG_W-1:0]  num_ff, num_in;
   logic [1:0]        idx_ff, idx_in;
   logic [ITER_W-1:0] cnt_ff, cnt_in;
   logic [PROD_W:0]   prod_ff, prod_in;
   logic [RAD_W-1:0]  sum_ff, sum_in, rad_ff, rad_in;
   logic [REM_W-1:0]  srem_ff, srem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [PROD_W-1:0] dvd_ff, dvd_in;
   logic [ROOT_W-1:0] drem_ff, drem_in;

   logic [31:0]       sq_op;
   logic [ROOT_W-1:0] mul_a;
   logic [31:0]       mul_b;
   logic [PROD_W:0]   mul_p;
   logic [REM_W-1:0]  srem_sh, trial;
   logic [ROOT_W:0]   drem_sh, den_ext;

   assign sq_op   = clamp_abs(vec_ff[idx_ff]);
   assign mul_a   = (state_ff == AR_MUL) ? a_ff : {1'b0, sq_op};
   assign mul_b   = (state_ff == AR_MUL) ? {1'b0, num_ff} : sq_op;
   assign mul_p   = mul_a * mul_b;
   assign srem_sh = {srem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
   assign trial   = {{(REM_W-ROOT_W-2){1'b0}}, root_ff, 2'b01};
   assign drem_sh = {drem_ff, dvd_ff[PROD_W-1]};
   assign den_ext = {1'b0, den_ff};

   always_comb begin
      state_in = state_ff;
      vec_in   = vec_ff;
      a_in     = a_ff;
      den_in   = den_ff;
      num_in   = num_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      prod_in  = prod_ff;
      sum_in   = sum_ff;
      rad_in   = rad_ff;
      srem_in  = srem_ff;
      root_in  = root_ff;
      dvd_in   = dvd_ff;
      drem_in  = drem_ff;
      case (state_ff)
         AR_IDLE: begin
            if (cmd.start) begin
               vec_in  = cmd.vec;
               a_in    = cmd.a;
               num_in  = cmd.num;
               den_in  = cmd.den;
               idx_in  = '0;
               sum_in  = '0;
               prod_in = '0;
               state_in = (cmd.op == OP_MAG) ? AR_SQ : AR_MUL;
            end
         end
         AR_SQ: begin
            // Squares are registered; each is added in the next cycle.
            prod_in = mul_p;
            sum_in  = sum_ff + RAD_W'(prod_ff);
            idx_in  = idx_ff + 1'b1;
            if (idx_ff == 2'd2) begin
               state_in = AR_ADD;
            end
         end
         AR_ADD: begin
            rad_in   = sum_ff + RAD_W'(prod_ff);
            srem_in  = '0;
            root_in  = '0;
            cnt_in   = '0;
            state_in = AR_SQRT;
         end
         AR_SQRT: begin
            rad_in = {rad_ff[RAD_W-3:0], 2'b00};
            if (srem_sh >= trial) begin
               srem_in = srem_sh - trial;
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               srem_in = srem_sh;
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == ITER_W'(ROOT_W - 1)) begin
               state_in = AR_DONE;
            end
         end
         AR_MUL: begin
            dvd_in   = mul_p[PROD_W-1:0];
            drem_in  = '0;
            cnt_in   = '0;
            state_in = AR_DIV;
         end
         AR_DIV: begin
            if (drem_sh >= den_ext) begin
               drem_in = ROOT_W'(drem_sh - den_ext);
               dvd_in  = {dvd_ff[PROD_W-2:0], 1'b1};
            end else begin
               drem_in = drem_sh[ROOT_W-1:0];
               dvd_in  = {dvd_ff[PROD_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == ITER_W'(PROD_W - 1)) begin
               state_in = AR_DONE;
            end
         end
         AR_DONE: begin
            state_in = AR_IDLE;
         end
         default: begin
            state_in = AR_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= AR_IDLE;
      end else begin
         state_ff <= state_in;
      end
      vec_ff  <= vec_in;
      a_ff    <= a_in;
      den_ff  <= den_in;
      num_ff  <= num_in;
      idx_ff  <= idx_in;
      cnt_ff  <= cnt_in;
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
      rad_ff  <= rad_in;
      srem_ff <= srem_in;
      root_ff <= root_in;
      dvd_ff  <= dvd_in;
      drem_ff <= drem_in;
   end

   assign rsp.done = (state_ff == AR_DONE);
   assign rsp.root = root_ff;
   assign rsp.quot = dvd_ff;

endmodule

/* rtl/psf_seq.sv */
// Step sequencer: walks the behaviours in priority order, drives the shared arithmetic
// unit and keeps the waypoint ring. Depends on psf_pkg, psf_arith and psf_wp_mem.
module psf_seq (
   input  logic              clock,
   input  logic              reset,
   input  psf_pkg::cfg_type  cfg,
   input  logic              start,
   input  psf_pkg::item_type item,
   output logic              idle,
   output logic              done,
   input  logic              done_ready,
   output psf_pkg::rsp_type  rsp
);
   import psf_pkg::*;

   typedef enum logic [15:0] {
      ST_IDLE  = 16'h0001,
      ST_BEH   = 16'h0002,
      ST_WPRD  = 16'h0004,
      ST_DMAG  = 16'h0008,
      ST_DMAGW = 16'h0010,
      ST_SPD   = 16'h0020,
      ST_SPDW  = 16'h0040,
      ST_COMP  = 16'h0080,
      ST_COMPW = 16'h0100,
      ST_TMAG  = 16'h0200,
      ST_TMAGW = 16'h0400,
      ST_FMAG  = 16'h0800,
      ST_FMAGW = 16'h1000,
      ST_SCL   = 16'h2000,
      ST_SCLW  = 16'h4000,
      ST_DONE  = 16'h8000
   } seq_state_type;

   seq_state_type     state_ff, state_in;
   logic [2:0]        beh_ff, beh_in;
   logic              go_ff, go_in;
   logic [1:0]        idx_ff, idx_in;
   logic              arr_ff, arr_in;
   logic              chk_ff, chk_in;
   word3_type         pos_ff, pos_in, vel_ff, vel_in, goal_ff, goal_in;
   vec_type           d_ff, d_in, f_ff, f_in, tot_ff, tot_in;
   logic [ROOT_W-1:0] m_ff, m_in, add_ff, add_in;
   logic [CFG_W-1:0]  speed_ff, speed_in, decel_ff, decel_in, rem_ff, rem_in;
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              limit_ff, limit_in, dropped_ff, dropped_in;

   arith_cmd_type     cmd;
   arith_rsp_type     ars;
   logic              wr_en, rd_en;
   logic [PTR_W-1:0]  wr_addr, rd_addr, next_head;
   word3_type         wp_rd;

   logic [TOT_W-1:0]  qv, sv, remv;
   logic              reached;

   psf_arith u_arith (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .rsp   (ars)
   );

   psf_wp_mem u_wp_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (item.goal),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (wp_rd)
   );

   assign next_head = wrap_ptr({1'b0, head_ff} + (PTR_W+1)'(1));
   assign wr_addr   = wrap_ptr((PTR_W+1)'(head_ff) + (PTR_W+1)'(count_ff));
   assign qv        = {{(TOT_W-32){1'b0}}, ars.quot[31:0]};
   assign remv      = {{(TOT_W-CFG_W){1'b0}}, cfg.max_force}
                      - {{(TOT_W-ROOT_W){1'b0}}, ars.root};
   // A middle waypoint counts at the radius, the last one at half of it.
   assign reached   = (count_ff > CNT_W'(1)) ? (ars.root < ROOT_W'(cfg.radius))
                                            : ({ars.root, 1'b0} < (ROOT_W+1)'(cfg.radius));

   always_comb begin
      state_in   = state_ff;
      beh_in     = beh_ff;
      go_in      = go_ff;
      idx_in     = idx_ff;
      arr_in     = arr_ff;
      chk_in     = chk_ff;
      pos_in     = pos_ff;
      vel_in     = vel_ff;
      goal_in    = goal_ff;
      d_in       = d_ff;
      f_in       = f_ff;
      tot_in     = tot_ff;
      m_in       = m_ff;
      add_in     = add_ff;
      speed_in   = speed_ff;
      decel_in   = decel_ff;
      rem_in     = rem_ff;
      head_in    = head_ff;
      count_in   = count_ff;
      limit_in   = limit_ff;
      dropped_in = dropped_ff;
      cmd        = '0;
      cmd.op     = OP_MAG;
      wr_en      = 1'b0;
      rd_en      = 1'b0;
      rd_addr    = head_ff;
      sv         = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               pos_in     = item.pos;
               vel_in     = item.vel;
               goal_in    = item.goal;
               tot_in     = '0;
               go_in      = 1'b1;
               beh_in     = '0;
               limit_in   = 1'b0;
               dropped_in = 1'b0;
               state_in   = ST_DONE;
               case (item.kind)
                  KIND_STEP: begin
                     state_in = ST_BEH;
                  end
                  KIND_PUSH: begin
                     if (count_ff >= CNT_W'(PATH_DEPTH)) begin
                        dropped_in = 1'b1;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  KIND_CLEAR: begin
                     head_in  = '0;
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_BEH: begin
            if (beh_ff[2]) begin
               limit_in = !go_ff;
               state_in = ST_DONE;
            end else if (!go_ff || !cfg.enable[beh_ff[1:0]]) begin
               beh_in = beh_ff + 1'b1;
            end else begin
               chk_in   = 1'b0;
               arr_in   = 1'b0;
               speed_in = cfg.max_speed;
               case (beh_ff[1:0])
                  BEH_FLEE: begin
                     for (int i = 0; i < 3; i++) begin
                        d_in[i] = sext32(pos_ff[i]) - sext32(goal_ff[i]);
                     end
                     state_in = ST_DMAG;
                  end
                  BEH_SEEK: begin
                     for (int i = 0; i < 3; i++) begin
                        d_in[i] = sext32(goal_ff[i]) - sext32(pos_ff[i]);
                     end
                     state_in = ST_DMAG;
                  end
                  BEH_ARRIVE: begin
                     for (int i = 0; i < 3; i++) begin
                        d_in[i] = sext32(goal_ff[i]) - sext32(pos_ff[i]);
                     end
                     arr_in   = 1'b1;
                     decel_in = cfg.decel;
                     state_in = ST_DMAG;
                  end
                  BEH_PATH: begin
                     if (count_ff == '0) begin
                        f_in     = '0;
                        state_in = ST_TMAG;
                     end else begin
                        rd_en    = 1'b1;
                        chk_in   = 1'b1;
                        arr_in   = (count_ff == CNT_W'(1));
                        decel_in = FIX_ONE;
                        state_in = ST_WPRD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WPRD: begin
            for (int i = 0; i < 3; i++) begin
               d_in[i] = sext32(wp_rd[i]) - sext32(pos_ff[i]);
            end
            state_in = ST_DMAG;
         end
         ST_DMAG: begin
            cmd.start = 1'b1;
            cmd.op    = OP_MAG;
            cmd.vec   = d_ff;
            state_in  = ST_DMAGW;
         end
         ST_DMAGW: begin
            if (ars.done) begin
               m_in   = ars.root;
               chk_in = 1'b0;
               idx_in = '0;
               if (chk_ff && reached) begin
                  head_in  = next_head;
                  count_in = count_ff - 1'b1;
                  if (count_ff > CNT_W'(1)) begin
                     // Seek the new front waypoint.
                     rd_en    = 1'b1;
                     rd_addr  = next_head;
                     state_in = ST_WPRD;
                  end else begin
                     f_in     = '0;
                     state_in = ST_TMAG;
                  end
               end else if (arr_ff) begin
                  if (ars.root <= ROOT_W'(ARRIVE_EPS)) begin
                     f_in     = '0;
                     state_in = ST_TMAG;
                  end else if (decel_ff == '0) begin
                     state_in = ST_COMP;
                  end else begin
                     state_in = ST_SPD;
                  end
               end else begin
                  state_in = ST_COMP;
               end
            end
         end
         ST_SPD: begin
            cmd.start = 1'b1;
            cmd.op    = OP_MULDIV;
            cmd.a     = m_ff;
            cmd.num   = FIX_ONE;
            cmd.den   = ROOT_W'(decel_ff);
            state_in  = ST_SPDW;
         end
         ST_SPDW: begin
            if (ars.done) begin
               if (ars.quot > PROD_W'(cfg.max_speed)) begin
                  speed_in = cfg.max_speed;
               end else begin
                  speed_in = ars.quot[CFG_W-1:0];
               end
               state_in = ST_COMP;
            end
         end
         ST_COMP: begin
            if (m_ff == '0) begin
               // A zero direction normalizes to zero.
               f_in[idx_ff] = '0 - sext32(vel_ff[idx_ff]);
               idx_in       = idx_ff + 1'b1;
               if (idx_ff == 2'd2) begin
                  state_in = ST_TMAG;
               end
            end else begin
               cmd.start = 1'b1;
               cmd.op    = OP_MULDIV;
               cmd.a     = {1'b0, clamp_abs(d_ff[idx_ff])};
               cmd.num   = speed_ff;
               cmd.den   = m_ff;
               state_in  = ST_COMPW;
            end
         end
         ST_COMPW: begin
            if (ars.done) begin
               sv           = d_ff[idx_ff][TOT_W-1] ? ('0 - qv) : qv;
               f_in[idx_ff] = sv - sext32(vel_ff[idx_ff]);
               idx_in       = idx_ff + 1'b1;
               state_in     = (idx_ff == 2'd2) ? ST_TMAG : ST_COMP;
            end
         end
         ST_TMAG: begin
            cmd.start = 1'b1;
            cmd.op    = OP_MAG;
            cmd.vec   = tot_ff;
            state_in  = ST_TMAGW;
         end
         ST_TMAGW: begin
            if (ars.done) begin
               if (remv[TOT_W-1] || remv == '0) begin
                  go_in    = 1'b0;
                  beh_in   = beh_ff + 1'b1;
                  state_in = ST_BEH;
               end else begin
                  rem_in   = remv[CFG_W-1:0];
                  state_in = ST_FMAG;
               end
            end
         end
         ST_FMAG: begin
            cmd.start = 1'b1;
            cmd.op    = OP_MAG;
            cmd.vec   = f_ff;
            state_in  = ST_FMAGW;
         end
         ST_FMAGW: begin
            if (ars.done) begin
               add_in = ars.root;
               idx_in = '0;
               if (ars.root < ROOT_W'(rem_ff)) begin
                  for (int i = 0; i < 3; i++) begin
                     tot_in[i] = tot_ff[i] + f_ff[i];
                  end
                  beh_in   = beh_ff + 1'b1;
                  state_in = ST_BEH;
               end else begin
                  // This force crosses the limit: scale it to fill what is left.
                  go_in    = 1'b0;
                  state_in = ST_SCL;
               end
            end
         end
         ST_SCL: begin
            cmd.start = 1'b1;
            cmd.op    = OP_MULDIV;
            cmd.a     = {1'b0, clamp_abs(f_ff[idx_ff])};
            cmd.num   = rem_ff;
            cmd.den   = add_ff;
            state_in  = ST_SCLW;
         end
         ST_SCLW: begin
            if (ars.done) begin
               sv             = f_ff[idx_ff][TOT_W-1] ? ('0 - qv) : qv;
               tot_in[idx_ff] = tot_ff[idx_ff] + sv;
               idx_in         = idx_ff + 1'b1;
               if (idx_ff == 2'd2) begin
                  beh_in   = beh_ff + 1'b1;
                  state_in = ST_BEH;
               end else begin
                  state_in = ST_SCL;
               end
            end
         end
         ST_DONE: begin
            if (done_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
      beh_ff     <= beh_in;
      go_ff      <= go_in;
      idx_ff     <= idx_in;
      arr_ff     <= arr_in;
      chk_ff     <= chk_in;
      pos_ff     <= pos_in;
      vel_ff     <= vel_in;
      goal_ff    <= goal_in;
      d_ff       <= d_in;
      f_ff       <= f_in;
      tot_ff     <= tot_in;
      m_ff       <= m_in;
      add_ff     <= add_in;
      speed_ff   <= speed_in;
      decel_ff   <= decel_in;
      rem_ff     <= rem_in;
      limit_ff   <= limit_in;
      dropped_ff <= dropped_in;
   end

   assign idle               = (state_ff == ST_IDLE);
   assign done               = (state_ff == ST_DONE);
   assign rsp.force_x        = sat32(tot_ff[0]);
   assign rsp.force_y        = sat32(tot_ff[1]);
   assign rsp.force_z        = sat32(tot_ff[2]);
   assign rsp.limit_reached  = limit_ff;
   assign rsp.waypoints_left = count_ff;
   assign rsp.push_dropped   = dropped_ff;

endmodule

/* rtl/prioritized_steering_force.sv */
// Top level of the prioritized steering force block: stream ports, register file and
// result register around the step sequencer. Depends on psf_pkg and psf_seq.
//
//   channel  dir  ports        contents
//   req      in   req_t*       one word: a step, a waypoint push or a path clear
//   rsp      out  rsp_t*       one word per request: force, flags, waypoint count
//   csr      in   csr_p*       APB-style register writes and reads
//
// A push, a clear or an unknown kind goes straight to the result. A step takes longer
// with more behaviors enabled: each magnitude runs through the bit-serial square root
// and each scaled component through the bit-serial divider of the shared arithmetic
// unit.
// Reset is synchronous; the waypoint ring comes up empty and needs no clearing pass.
// A finished word waits in the result register while the next request is taken.
module prioritized_steering_force (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, goal_x, goal_y, goal_z
   input  logic [psf_pkg::REQ_DW-1:0]    req_tdata,
   // kind
   input  logic [1:0]                    req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // force_x, force_y, force_z, waypoints_left, zero fill
   output logic [psf_pkg::RSP_DW-1:0]    rsp_tdata,
   // limit_reached, push_dropped
   output logic [1:0]                    rsp_tuser,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [psf_pkg::ADDR_W-1:0]    csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);
   import psf_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   item_type  item;
   rsp_type   seq_rsp, out_ff, out_in;
   logic      out_valid_ff, out_valid_in;
   logic      seq_idle, seq_done, load;
   logic      csr_wr;
   logic [2:0] reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[ADDR_W-1:2];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (reg_idx)
            REG_ENABLE:    cfg_in.enable    = csr_pwdata[3:0];
            REG_MAX_FORCE: cfg_in.max_force = csr_pwdata[CFG_W-1:0];
            REG_MAX_SPEED: cfg_in.max_speed = csr_pwdata[CFG_W-1:0];
            REG_DECEL:     cfg_in.decel     = csr_pwdata[CFG_W-1:0];
            REG_RADIUS:    cfg_in.radius    = csr_pwdata[CFG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_ENABLE:    csr_prdata = {28'd0, cfg_ff.enable};
         REG_MAX_FORCE: csr_prdata = {1'b0, cfg_ff.max_force};
         REG_MAX_SPEED: csr_prdata = {1'b0, cfg_ff.max_speed};
         REG_DECEL:     csr_prdata = {1'b0, cfg_ff.decel};
         REG_RADIUS:    csr_prdata = {1'b0, cfg_ff.radius};
         default:       csr_prdata = '0;
      endcase
   end

   always_comb begin
      item.kind = req_tuser;
      for (int i = 0; i < 3; i++) begin
         item.pos[i]  = req_tdata[32*i +: 32];
         item.vel[i]  = req_tdata[32*(i+3) +: 32];
         item.goal[i] = req_tdata[32*(i+6) +: 32];
      end
   end

   assign req_tready = seq_idle;

   psf_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .start      (req_tvalid & seq_idle),
      .item       (item),
      .idle       (seq_idle),
      .done       (seq_done),
      .done_ready (load),
      .rsp        (seq_rsp)
   );

   assign load         = seq_done & (!out_valid_ff | rsp_tready);
   assign out_valid_in = load | (out_valid_ff & !rsp_tready);
   assign out_in       = load ? seq_rsp : out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff     <= 1'b0;
         cfg_ff.enable    <= '0;
         cfg_ff.max_force <= FIX_ONE;
         cfg_ff.max_speed <= FIX_ONE;
         cfg_ff.decel     <= FIX_ONE;
         cfg_ff.radius    <= CFG_W'(3932);
      end else begin
         out_valid_ff <= out_valid_in;
         cfg_ff       <= cfg_in;
      end
      out_ff <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DW-96-CNT_W){1'b0}}, out_ff.waypoints_left,
                        out_ff.force_z, out_ff.force_y, out_ff.force_x};
   assign rsp_tuser  = {out_ff.push_dropped, out_ff.limit_reached};

endmodule
